@@ rtl/core/ipr_pkg.sv @@
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and constants for the indexed piece reassembly core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned MAX_PIECES_DEF  = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RADDR_W  = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CHUNK_W  = 13;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd256;

  // wide enough for the largest store the core supports
  localparam int unsigned ADDR_MAX_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_HEADER = 2'd0,
    OP_BYTE   = 2'd1,
    OP_READ   = 2'd2
  } ipr_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT   = 3'd0,
    ST_REJECT   = 3'd1,
    ST_STORED   = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_READ     = 3'd5
  } ipr_status_e;

  typedef struct packed {
    logic                  en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } ipr_wr_t;

  typedef struct packed {
    ipr_status_e       status;
    logic [LEN_W-1:0]  length;
  } ipr_res_t;

endpackage

`default_nettype wire

@@ rtl/core/ipr_tracker.sv @@
// ----------------------------------------------------------------------------
// ipr_tracker
// Piece bookkeeping: header checks, expected/seen masks, write pointer,
// byte countdown and payload length. Produces the status of each word and
// the store write request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipr_tracker #(
  parameter int unsigned STORE_BYTES = ipr_pkg::STORE_BYTES_DEF,
  parameter int unsigned MAX_PIECES  = ipr_pkg::MAX_PIECES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire ipr_pkg::ipr_op_e             op_i,
  input  wire logic [ipr_pkg::IDX_W-1:0]    piece_index_i,
  input  wire logic [ipr_pkg::IDX_W-1:0]    piece_total_i,
  input  wire logic [ipr_pkg::LEN_W-1:0]    content_length_i,
  input  wire logic [ipr_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic [ipr_pkg::CHUNK_W-1:0]  chunk_size_i,
  output ipr_pkg::ipr_res_t                 res_o,
  output ipr_pkg::ipr_wr_t                  wr_o
);
  import ipr_pkg::*;

  localparam int unsigned PTR_W   = $clog2(STORE_BYTES + 1);
  localparam int unsigned PIECE_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int unsigned PROD_W  = PIECE_W + CHUNK_W;

  logic [MAX_PIECES-1:0] exp_q, exp_d;
  logic [MAX_PIECES-1:0] seen_q, seen_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [PTR_W-1:0]      wp_q, wp_d;
  logic [LEN_W-1:0]      rem_q, rem_d;
  logic [PIECE_W-1:0]    cur_q, cur_d;
  logic                  fin_q, fin_d;

  logic [PIECE_W-1:0]    hdr_piece;
  logic [PROD_W-1:0]     hdr_offset;
  logic [PROD_W:0]       hdr_end;
  logic                  hdr_bad;
  logic [MAX_PIECES-1:0] hdr_mask;

  logic                  do_finish;
  logic [PIECE_W-1:0]    f_piece;
  logic                  f_final;
  logic [PTR_W-1:0]      f_wp;
  logic [MAX_PIECES-1:0] f_exp;
  logic [MAX_PIECES-1:0] f_seen;
  logic [MAX_PIECES-1:0] piece_bit;
  logic [MAX_PIECES-1:0] seen_set;
  ipr_status_e           status;

  assign hdr_piece  = piece_index_i[PIECE_W-1:0];
  assign hdr_offset = PROD_W'(hdr_piece) * PROD_W'(chunk_size_i);
  assign hdr_end    = (PROD_W + 1)'(hdr_offset) + (PROD_W + 1)'(content_length_i);
  assign hdr_bad    = (piece_total_i == '0) || (32'(piece_total_i) > MAX_PIECES)
                   || (piece_index_i >= piece_total_i) || (32'(hdr_end) > STORE_BYTES);

  always_comb begin
    for (int i = 0; i < MAX_PIECES; i++) begin
      hdr_mask[i] = (32'(i) < 32'(piece_total_i));
    end
  end

  always_comb begin
    exp_d     = exp_q;
    seen_d    = seen_q;
    len_d     = len_q;
    wp_d      = wp_q;
    rem_d     = rem_q;
    cur_d     = cur_q;
    fin_d     = fin_q;
    status    = ST_IGNORED;
    wr_o      = '0;
    do_finish = 1'b0;
    f_piece   = cur_q;
    f_final   = fin_q;
    f_wp      = wp_q;
    f_exp     = exp_q;
    f_seen    = seen_q;

    unique case (op_i)
      OP_HEADER: begin
        if (hdr_bad) begin
          rem_d  = '0;
          status = ST_REJECT;
        end else begin
          if (piece_index_i == '0 || exp_q == '0) begin
            exp_d  = hdr_mask;
            seen_d = '0;
          end
          wp_d      = PTR_W'(hdr_offset);
          rem_d     = content_length_i;
          cur_d     = hdr_piece;
          fin_d     = (piece_index_i == piece_total_i - 8'd1);
          status    = ST_ACCEPT;
          do_finish = (content_length_i == '0);
          f_piece   = cur_d;
          f_final   = fin_d;
          f_wp      = wp_d;
          f_exp     = exp_d;
          f_seen    = seen_d;
        end
      end
      OP_BYTE: begin
        if (rem_q != '0) begin
          wr_o.en   = (32'(wp_q) < STORE_BYTES);
          wr_o.addr = ADDR_MAX_W'(wp_q);
          wr_o.data = data_byte_i;
          wp_d      = wp_q + PTR_W'(1);
          rem_d     = rem_q - LEN_W'(1);
          status    = ST_STORED;
          do_finish = (rem_d == '0);
          f_wp      = wp_d;
        end
      end
      OP_READ: begin
        status = ST_READ;
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase

    // piece end: mark it seen, fix length on the final piece, check for whole
    for (int i = 0; i < MAX_PIECES; i++) begin
      piece_bit[i] = (f_piece == PIECE_W'(i));
    end
    seen_set = f_seen | piece_bit;
    if (do_finish) begin
      seen_d = seen_set;
      if (f_final) begin
        len_d = LEN_W'(f_wp);
      end
      if (f_exp != '0 && seen_set == f_exp) begin
        exp_d  = '0;
        seen_d = '0;
        status = ST_COMPLETE;
      end
    end

    if (!fire_i) begin
      wr_o.en = 1'b0;
    end
  end

  assign res_o.status = status;
  assign res_o.length = len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= '0;
      seen_q <= '0;
      len_q  <= '0;
      wp_q   <= '0;
      rem_q  <= '0;
      cur_q  <= '0;
      fin_q  <= 1'b0;
    end else if (fire_i) begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      len_q  <= len_d;
      wp_q   <= wp_d;
      rem_q  <= rem_d;
      cur_q  <= cur_d;
      fin_q  <= fin_d;
    end
  end

  a_complete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && status == ST_COMPLETE |=> exp_q == '0 && seen_q == '0)
    else $error("masks not cleared after completion");

  a_ptr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> 32'(wp_q) < STORE_BYTES)
    else $error("bytes pending but write pointer past store");

  a_stray_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && op_i == OP_BYTE && rem_q == '0 |-> status == ST_IGNORED)
    else $error("stray byte not ignored");

endmodule

`default_nettype wire

@@ rtl/core/indexed_piece_reassembly_core.sv @@
// ----------------------------------------------------------------------------
// indexed_piece_reassembly_core
// Pipeline: two register stages (input register, then result register with the
// registered store read); a word advances whenever the result is empty or taken.
// Throughput: one word per cycle while the output is not stalled; while a
// finished result is stalled, a new word can still enter an empty input register.
// Reset: masks, pointers, counters and handshake state clear; chunk size
// returns to 256. Store contents are undefined until written (no clearing).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_piece_reassembly_core #(
  parameter int unsigned STORE_BYTES = ipr_pkg::STORE_BYTES_DEF,
  parameter int unsigned MAX_PIECES  = ipr_pkg::MAX_PIECES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ipr_pkg::CHUNK_W-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [ipr_pkg::OP_W-1:0]       operation_i,
  input  wire logic [ipr_pkg::IDX_W-1:0]      piece_index_i,
  input  wire logic [ipr_pkg::IDX_W-1:0]      piece_total_i,
  input  wire logic [ipr_pkg::LEN_W-1:0]      content_length_i,
  input  wire logic [ipr_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic [ipr_pkg::RADDR_W-1:0]    read_address_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [ipr_pkg::STATUS_W-1:0]   status_o,
  output      logic [ipr_pkg::LEN_W-1:0]      payload_length_o,
  output      logic [ipr_pkg::BYTE_W-1:0]     read_data_o
);
  import ipr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

  logic [CHUNK_W-1:0] chunk_q;

  logic               s1_valid_q;
  logic [OP_W-1:0]    s1_op_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [IDX_W-1:0]   s1_tot_q;
  logic [LEN_W-1:0]   s1_len_q;
  logic [BYTE_W-1:0]  s1_byte_q;
  logic [RADDR_W-1:0] s1_addr_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [LEN_W-1:0]    out_len_q;
  logic [BYTE_W-1:0]   out_rdata_q;

  logic [BYTE_W-1:0]  store_mem [STORE_BYTES];

  logic        advance;
  logic        fire;
  logic        in_acc;
  logic        rd_hit;
  logic [ADDR_W-1:0] rd_idx;
  ipr_res_t    res;
  ipr_wr_t     wr;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign rd_hit = (s1_op_q == OP_READ) && (32'(s1_addr_q) < STORE_BYTES);
  assign rd_idx = ADDR_W'(s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
    end else if (cfg_we_i) begin
      chunk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= operation_i;
      s1_idx_q  <= piece_index_i;
      s1_tot_q  <= piece_total_i;
      s1_len_q  <= content_length_i;
      s1_byte_q <= data_byte_i;
      s1_addr_q <= read_address_i;
    end
    if (fire) begin
      out_status_q <= res.status;
      out_len_q    <= res.length;
    end
  end

  // byte store: one write port from the tracker, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      store_mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (fire) begin
      out_rdata_q <= rd_hit ? store_mem[rd_idx] : '0;
    end
  end

  ipr_tracker #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_PIECES  (MAX_PIECES)
  ) u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .op_i             (ipr_op_e'(s1_op_q)),
    .piece_index_i    (s1_idx_q),
    .piece_total_i    (s1_tot_q),
    .content_length_i (s1_len_q),
    .data_byte_i      (s1_byte_q),
    .chunk_size_i     (chunk_q),
    .res_o            (res),
    .wr_o             (wr)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign payload_length_o = out_len_q;
  assign read_data_o      = out_rdata_q;

  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_READ |-> read_data_o == '0)
    else $error("read data nonzero on a non-read result");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipe");

  a_write_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> fire && s1_op_q == OP_BYTE)
    else $error("store write without a byte word advancing");

endmodule

`default_nettype wire

@@ dv/indexed_piece_reassembly_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_piece_reassembly_core_tb
// Self-checking bench for the piece reassembly core. Directed tests cover
// header checks, empty and abandoned pieces, stray words and the store edges.
// Random phases then send whole payloads with shuffled pieces, mixed with
// noise, over several chunk sizes. Both sides idle and stall at random. Each
// result word is checked against a behavioral prediction of the core state.
// ----------------------------------------------------------------------------
module indexed_piece_reassembly_core_tb;
  import ipr_pkg::*;

  localparam int unsigned STORE          = STORE_BYTES_DEF;
  localparam int unsigned PIECES         = MAX_PIECES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam int unsigned GAP_MAX        = 14;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS    = 225;

  typedef struct {
    ipr_status_e       status;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] rdata;
  } reassembly_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CHUNK_W-1:0]   cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      operation_i;
  logic [IDX_W-1:0]     piece_index_i;
  logic [IDX_W-1:0]     piece_total_i;
  logic [LEN_W-1:0]     content_length_i;
  logic [BYTE_W-1:0]    data_byte_i;
  logic [RADDR_W-1:0]   read_address_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [LEN_W-1:0]     payload_length_o;
  logic [BYTE_W-1:0]    read_data_o;

  // predicted core state
  logic [CHUNK_W-1:0]   chunk_bytes;
  logic [31:0]          mask_expected;
  logic [31:0]          mask_seen;
  logic [BYTE_W-1:0]    store_mem [STORE];
  bit                   store_written [STORE];
  int unsigned          written_addrs [$];
  int unsigned          length_reg;
  int unsigned          wr_ptr;
  int unsigned          remaining;
  logic [4:0]           cur_piece;
  bit                   cur_final;

  reassembly_result_t   pending_results [$];
  int unsigned          words_sent;
  int unsigned          fail_count;
  int unsigned          idle_cycles;
  bit                   steady;

  indexed_piece_reassembly_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .piece_index_i    (piece_index_i),
    .piece_total_i    (piece_total_i),
    .content_length_i (content_length_i),
    .data_byte_i      (data_byte_i),
    .read_address_i   (read_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .read_data_o      (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Marks the current piece as arrived; true when the payload is whole.
  function automatic bit close_piece();
    mask_seen |= 32'd1 << cur_piece;
    if (cur_final) length_reg = wr_ptr;
    if (mask_expected != '0 && mask_seen == mask_expected) begin
      mask_expected = '0;
      mask_seen = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic ipr_status_e take_header(input int unsigned idx,
                                              input int unsigned total,
                                              input int unsigned len);
    int unsigned offset;
    if (total == 0 || total > PIECES || idx >= total) begin
      remaining = 0;
      return ST_REJECT;
    end
    offset = idx * chunk_bytes;
    if (offset + len > STORE) begin
      remaining = 0;
      return ST_REJECT;
    end
    if (idx == 0 || mask_expected == '0) begin
      mask_expected = (total >= 32) ? '1 : ((32'd1 << total) - 32'd1);
      mask_seen = '0;
    end
    wr_ptr = offset;
    remaining = len;
    cur_piece = idx[4:0];
    cur_final = (idx == total - 1);
    if (len == 0) return close_piece() ? ST_COMPLETE : ST_ACCEPT;
    return ST_ACCEPT;
  endfunction

  function automatic ipr_status_e take_byte(input logic [BYTE_W-1:0] value);
    if (remaining == 0) return ST_IGNORED;
    if (wr_ptr < STORE) begin
      store_mem[wr_ptr] = value;
      if (!store_written[wr_ptr]) begin
        store_written[wr_ptr] = 1'b1;
        written_addrs.push_back(wr_ptr);
      end
    end
    wr_ptr++;
    remaining--;
    if (remaining == 0 && close_piece()) return ST_COMPLETE;
    return ST_STORED;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Drives one word after a random gap and predicts its result on accept.
  task automatic send_word(input int unsigned op, input int unsigned idx,
                           input int unsigned total, input int unsigned len,
                           input int unsigned data, input int unsigned addr);
    int unsigned gap;
    reassembly_result_t want;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i      <= op[OP_W-1:0];
    piece_index_i    <= idx[IDX_W-1:0];
    piece_total_i    <= total[IDX_W-1:0];
    content_length_i <= len[LEN_W-1:0];
    data_byte_i      <= data[BYTE_W-1:0];
    read_address_i   <= addr[RADDR_W-1:0];
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    want.rdata = '0;
    case (op[OP_W-1:0])
      OP_HEADER: want.status = take_header(idx[IDX_W-1:0], total[IDX_W-1:0],
                                           len[LEN_W-1:0]);
      OP_BYTE:   want.status = take_byte(data[BYTE_W-1:0]);
      OP_READ: begin
        want.status = ST_READ;
        want.rdata = store_mem[addr[RADDR_W-1:0]];
      end
      default:   want.status = ST_IGNORED;
    endcase
    want.length = length_reg[LEN_W-1:0];
    pending_results.push_back(want);
  endtask

  task automatic send_header(input int unsigned idx, input int unsigned total,
                             input int unsigned len);
    send_word(OP_HEADER, idx, total, len, $urandom_range(0, 255), $urandom_range(0, 4095));
  endtask

  task automatic send_byte(input int unsigned value);
    send_word(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 8191), value, $urandom_range(0, 4095));
  endtask

  task automatic send_content(input int unsigned count);
    repeat (count) send_byte($urandom_range(0, 255));
  endtask

  task automatic send_read(input int unsigned addr);
    send_word(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 8191), $urandom_range(0, 255), addr);
  endtask

  // only addresses already written are read back
  task automatic send_read_any();
    if (written_addrs.size() != 0)
      send_read(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_chunk(input int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[CHUNK_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    chunk_bytes = value[CHUNK_W-1:0];
  endtask

  task automatic test_default_chunk();
    send_header(0, 2, 2);
    send_byte(8'h00);
    send_byte(8'hff);
    send_header(1, 2, 3);
    send_content(3);
    send_read(0);
    send_read(257);
  endtask

  task automatic test_header_checks();
    send_header(0, 0, 1);
    send_header(0, 33, 1);
    send_header(255, 255, 0);
    send_header(3, 3, 0);
    send_header(31, 32, 1);
    send_header(0, 1, 8191);
    // a rejected header drops the piece in progress
    send_header(0, 2, 3);
    send_byte(8'ha5);
    send_header(32, 32, 0);
    send_byte(8'h5a);
  endtask

  task automatic test_stray_and_unused();
    send_byte(8'h3c);
    send_word(OP_UNUSED, 255, 255, 8191, 255, 4095);
  endtask

  task automatic test_empty_pieces();
    send_header(0, 1, 0);
    send_header(0, 2, 0);
    send_header(1, 2, 0);
  endtask

  task automatic test_abandoned_piece();
    send_header(0, 2, 3);
    send_byte(8'h11);
    send_header(1, 2, 1);
    send_byte(8'h22);
    send_byte(8'h33);
  endtask

  task automatic test_store_top();
    set_chunk(4095);
    send_header(1, 2, 1);
    send_byte(8'hff);
    send_read(4095);
  endtask

  task automatic run_payloads(input int unsigned quota);
    int unsigned first, total, top, k, j, tmp, idx, len, offset, room, cap;
    int unsigned ord [PIECES];
    first = words_sent;
    while (words_sent - first < quota) begin
      steady = ($urandom_range(0, 5) == 0);
      top = (chunk_bytes == 0) ? PIECES : lesser(PIECES, STORE / chunk_bytes + 1);
      total = ($urandom_range(0, 5) == 0) ? $urandom_range(1, top)
                                          : $urandom_range(1, lesser(top, 4));
      for (k = 0; k < total; k++) ord[k] = k;
      // piece 0 goes first, the rest in random order
      for (k = total - 1; k > 1; k--) begin
        j = $urandom_range(1, k);
        tmp = ord[k];
        ord[k] = ord[j];
        ord[j] = tmp;
      end
      for (k = 0; k < total; k++) begin
        idx = ord[k];
        offset = idx * chunk_bytes;
        room = (offset > STORE) ? 0 : STORE - offset;
        cap = ($urandom_range(0, 15) == 0) ? 64 : 6;
        len = $urandom_range(0, lesser(room, cap));
        case ($urandom_range(0, 24))
          0: send_header($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 8191));
          1: send_byte($urandom_range(0, 255));
          2: send_word(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 8191), $urandom_range(0, 255),
                       $urandom_range(0, 4095));
          3: send_read_any();
          default: ;
        endcase
        send_header(idx, total, len);
        // a piece cut short is abandoned by the next header
        send_content(($urandom_range(0, 19) == 0) ? len / 2 : len);
        if ($urandom_range(0, 3) == 0) send_read_any();
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random_payloads();
    int unsigned chunk_list [$];
    chunk_list = '{1, 4096, 0, 8191, 128, 37, 256};
    chunk_list.push_back($urandom_range(1, 4096));
    foreach (chunk_list[p]) begin
      set_chunk(chunk_list[p]);
      run_payloads(PHASE_WORDS);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    reassembly_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (payload_length_o !== want.length)
          report_mismatch("payload_length", payload_length_o, want.length);
        if (read_data_o !== want.rdata) report_mismatch("read_data", read_data_o, want.rdata);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL indexed_piece_reassembly_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drive_out_stall
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    operation_i      = OP_HEADER;
    piece_index_i    = '0;
    piece_total_i    = '0;
    content_length_i = '0;
    data_byte_i      = '0;
    read_address_i   = '0;
    chunk_bytes      = CHUNK_RESET;
    mask_expected    = '0;
    mask_seen        = '0;
    length_reg       = 0;
    wr_ptr           = 0;
    remaining        = 0;
    cur_piece        = '0;
    cur_final        = 1'b0;
    words_sent       = 0;
    fail_count       = 0;
    idle_cycles      = 0;
    steady           = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_chunk();
    test_header_checks();
    test_stray_and_unused();
    test_empty_pieces();
    test_abandoned_piece();
    test_store_top();
    test_random_payloads();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS indexed_piece_reassembly_core");
    end else begin
      $display("FAIL indexed_piece_reassembly_core");
    end
    $finish;
  end

endmodule
